@@ design/eca_pkg.sv @@
// Shared types and constants for the encoder count unwrap accumulator.
// Holds command codes, field widths and the saturation limits used in the datapath.
// No dependencies.
`default_nettype none

package eca_pkg;

  localparam int CountW = 32;
  localparam int ValueW = 48;
  localparam int ResW   = 6;

  typedef logic [1:0]               cmd_t;
  typedef logic signed [CountW-1:0] count_t;
  typedef logic signed [ValueW-1:0] value_t;

  localparam cmd_t CMD_DECODE = 2'd0;
  localparam cmd_t CMD_ENCODE = 2'd1;
  localparam cmd_t CMD_SET    = 2'd2;
  localparam cmd_t CMD_NONE   = 2'd3;

  localparam logic [1:0] REG_RESOLUTION = 2'd0;
  localparam logic [1:0] REG_VAL_PER_CNT = 2'd1;
  localparam logic [1:0] REG_CNT_PER_VAL = 2'd2;

  localparam logic [ResW-1:0] RES_RESET = 6'd32;
  localparam logic [31:0]     SCALE_ONE = 32'h0001_0000;

  // decode product clamp, +/- 2^49
  localparam logic signed [63:0] PROD_LIM = 64'sh0002_0000_0000_0000;

  localparam value_t POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam value_t POS_MIN = 48'sh8000_0000_0000;
  localparam count_t CNT_MAX = 32'sh7FFF_FFFF;
  localparam count_t CNT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

@@ design/encoder_count_unwrap_accumulator.sv @@
// Rotary encoder count unwrap and scaled position accumulator, top level.
// Depends on eca_pkg for command codes, widths and saturation limits.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   decode a raw counter reading, encode a Q32.16 position into a count, or
//   set count and position directly. Each transaction returns exactly one
//   result on the output channel (out_valid/out_ready): the position after
//   the command and the count change it applied.
//   The cfg_ port writes resolution_bits (0), value_per_count (1) and
//   counts_per_value (2); write it only while the block is idle.
// Pipeline:
//   Three register stages: input, multiply/unwrap, position/output. Decode,
//   set and the unused command pass at one transaction per cycle while
//   out_ready stays high. Encode holds the input stage until its 48x32
//   scaling multiply, split into two registered 24x32 partial products, is
//   summed in the next cycle, so no new transaction enters behind an encode
//   until that sum is formed.
// Reset: rst_n (synchronous, active low) clears last count and position to
//   zero, loads register defaults (32 bits, scales of 1.0) and empties the pipe.
// Stall: when out_ready is low the output register holds its result; the
//   stages behind it keep filling until full, then in_ready drops.
`default_nettype none

module encoder_count_unwrap_accumulator (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire eca_pkg::cmd_t     in_command,
  input  wire eca_pkg::count_t   in_count_in,
  input  wire eca_pkg::value_t   in_value_in,
  output logic                   out_valid,
  input  wire                    out_ready,
  output eca_pkg::value_t        out_value_out,
  output eca_pkg::count_t        out_count_delta,
  input  wire                    cfg_we,
  input  wire [1:0]              cfg_index,
  input  wire [31:0]             cfg_wdata
);
  import eca_pkg::*;

  // configuration
  logic [ResW-1:0] res_r;
  logic [31:0]     vpc_r;
  logic [31:0]     cpv_r;

  // state
  logic [CountW-1:0] last_count_r, last_count_nxt;
  value_t            pos_r, pos_nxt;

  // stage A: input register
  logic   a_vld_r;
  cmd_t   a_cmd_r;
  count_t a_count_r;
  value_t a_value_r;
  logic   a_phase_r;
  logic   enc_neg_r;
  logic [55:0] pl_r, ph_r;

  // stage B: product / load register
  logic               b_vld_r;
  cmd_t               b_cmd_r;
  logic signed [63:0] b_prod_r;
  value_t             b_value_r;
  count_t             b_delta_r;

  // output register
  logic   out_valid_r;
  value_t out_value_r;
  count_t out_delta_r;

  logic o_free, b_go, b_free, a_done, a_go, a_free, in_take;

  assign o_free   = !out_valid_r || out_ready;
  assign b_go     = b_vld_r && o_free;
  assign b_free   = !b_vld_r || b_go;
  assign a_done   = a_vld_r && ((a_cmd_r != CMD_ENCODE) || a_phase_r);
  assign a_go     = a_done && b_free;
  assign a_free   = !a_vld_r || a_go;
  assign in_ready = a_free;
  assign in_take  = in_valid && a_free;

  assign out_valid       = out_valid_r;
  assign out_value_out   = out_value_r;
  assign out_count_delta = out_delta_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_RESET;
      vpc_r <= SCALE_ONE;
      cpv_r <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESOLUTION:  res_r <= cfg_wdata[ResW-1:0];
        REG_VAL_PER_CNT: vpc_r <= cfg_wdata;
        REG_CNT_PER_VAL: cpv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage A: unwrap ----------------
  logic [ResW-1:0]    bits_eff;
  logic [4:0]         lim_sh;
  logic signed [33:0] lim, d_raw, dec_d;
  logic [CountW-1:0]  diff;
  count_t             dec_delta;
  logic signed [63:0] dec_mul;

  always_comb begin
    diff = a_count_r - last_count_r;
    d_raw = {{2{diff[CountW-1]}}, diff};
    if (res_r == '0) begin
      bits_eff = 6'd1;
    end else if (res_r > 6'd32) begin
      bits_eff = 6'd32;
    end else begin
      bits_eff = res_r;
    end
    lim_sh = 5'(bits_eff - 6'd1);
    lim = 34'sd1 <<< lim_sh;
    dec_d = d_raw;
    if (bits_eff < 6'd32) begin
      if (d_raw < -lim) begin
        dec_d = d_raw + (lim <<< 1);
      end else if (d_raw > lim) begin
        dec_d = d_raw - (lim <<< 1);
      end
    end
    dec_delta = dec_d[CountW-1:0];
    dec_mul = $signed(dec_delta) * $signed({1'b0, vpc_r});
  end

  // ---------------- stage A: encode scaling ----------------
  logic [ValueW-1:0] mag;
  logic [55:0]       pl_nxt, ph_nxt;
  logic [79:0]       enc_full;
  logic [47:0]       enc_q;
  count_t            enc_n;

  always_comb begin
    mag = a_value_r[ValueW-1] ? ValueW'(-a_value_r) : a_value_r;
    pl_nxt = mag[23:0] * cpv_r;
    ph_nxt = mag[47:24] * cpv_r;
    enc_full = {ph_r, 24'b0} + {24'b0, pl_r};
    enc_q = enc_full[79:32];
    if (enc_neg_r) begin
      enc_n = (enc_q > 48'h0000_8000_0000) ? CNT_MIN : -$signed(enc_q[31:0]);
    end else begin
      enc_n = (enc_q > 48'h0000_7FFF_FFFF) ? CNT_MAX : $signed(enc_q[31:0]);
    end
  end

  count_t a_delta;

  always_comb begin
    last_count_nxt = last_count_r;
    a_delta = '0;
    unique case (a_cmd_r)
      CMD_DECODE: begin
        a_delta = dec_delta;
        last_count_nxt = a_count_r;
      end
      CMD_ENCODE: begin
        a_delta = enc_n - last_count_r;
        last_count_nxt = enc_n;
      end
      CMD_SET:  last_count_nxt = a_count_r;
      CMD_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      a_phase_r    <= 1'b0;
      last_count_r <= '0;
    end else begin
      if (in_take) begin
        a_vld_r   <= 1'b1;
        a_phase_r <= 1'b0;
      end else if (a_go) begin
        a_vld_r   <= 1'b0;
        a_phase_r <= 1'b0;
      end else if (a_vld_r && a_cmd_r == CMD_ENCODE) begin
        a_phase_r <= 1'b1;
      end
      if (a_go) begin
        last_count_r <= last_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_cmd_r   <= in_command;
      a_count_r <= in_count_in;
      a_value_r <= in_value_in;
    end
    // capture partial products in the first phase of any command in stage A, hold them while an encode sums
    if (a_vld_r && !a_phase_r) begin
      pl_r      <= pl_nxt;
      ph_r      <= ph_nxt;
      enc_neg_r <= a_value_r[ValueW-1];
    end
  end

  // ---------------- stage B: position update ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_go) begin
      b_vld_r <= 1'b1;
    end else if (b_go) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_cmd_r   <= a_cmd_r;
      b_prod_r  <= dec_mul;
      b_value_r <= a_value_r;
      b_delta_r <= a_delta;
    end
  end

  logic signed [63:0] prod_c;
  logic signed [51:0] sum;

  always_comb begin
    if (b_prod_r > PROD_LIM) begin
      prod_c = PROD_LIM;
    end else if (b_prod_r < -PROD_LIM) begin
      prod_c = -PROD_LIM;
    end else begin
      prod_c = b_prod_r;
    end
    sum = {{4{pos_r[ValueW-1]}}, pos_r} + prod_c[51:0];
    pos_nxt = pos_r;
    unique case (b_cmd_r)
      CMD_DECODE: begin
        if (!sum[51] && (sum[50:47] != 4'b0000)) begin
          pos_nxt = POS_MAX;
        end else if (sum[51] && (sum[50:47] != 4'b1111)) begin
          pos_nxt = POS_MIN;
        end else begin
          pos_nxt = sum[ValueW-1:0];
        end
      end
      CMD_ENCODE, CMD_SET: pos_nxt = b_value_r;
      CMD_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_go) begin
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_value_r <= pos_nxt;
      out_delta_r <= b_delta_r;
    end
  end

  // ---------------- assertions ----------------
  a_enc_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && a_cmd_r == CMD_ENCODE && !a_phase_r) |-> !in_ready)
    else $error("input accepted while encode partial products pending");

  a_phase_only_encode: assert property (@(posedge clk) disable iff (!rst_n)
    a_phase_r |-> (a_vld_r && a_cmd_r == CMD_ENCODE))
    else $error("encode phase set without an encode in stage A");

  a_pos_moves_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    !b_go |=> $stable(pos_r))
    else $error("position changed without a stage B transaction");

  a_count_moves_on_go: assert property (@(posedge clk) disable iff (!rst_n)
    !a_go |=> $stable(last_count_r))
    else $error("last count changed without a stage A transaction");

  a_set_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
    (b_go && b_cmd_r == CMD_SET) |=> (out_count_delta == '0))
    else $error("set command produced a nonzero count delta");

endmodule

`default_nettype wire

@@ sim/tb_encoder_count_unwrap_accumulator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for encoder_count_unwrap_accumulator: directed table, then random
// command streams under several register settings and idle patterns. Depends on eca_pkg.

module tb_encoder_count_unwrap_accumulator;
  import eca_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 165;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;

  localparam logic signed [63:0] DECODE_CLAMP = 64'sd1 <<< 49;
  localparam logic signed [63:0] POS_HI = POS_MAX;
  localparam logic signed [63:0] POS_LO = POS_MIN;

  typedef struct packed {
    value_t pos;
    count_t delta;
  } pos_report_t;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [1:0] reg_sel;
    logic [31:0] reg_val;
    cmd_t cmd;
    count_t cnt;
    value_t val;
    logic has_want;
    value_t want_pos;
    count_t want_delta;
  } dir_step_t;

  localparam int N_DIRECTED = 32;
  localparam dir_step_t DIRECTED [N_DIRECTED] = '{
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd5, 48'sd0, 1'b1, 48'sh5_0000, 32'sd5},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_NONE, 32'sh1234_5678, 48'sh7777, 1'b1,
      48'sh5_0000, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_SET, 32'sd100, 48'sh0001_2345_6789, 1'b1,
      48'sh0001_2345_6789, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, 48'sd0, 1'b1, 48'sd0, -32'sd100},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_SET, 32'sd0, POS_MAX, 1'b1, POS_MAX, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd1, 48'sd0, 1'b1, POS_MAX, 32'sd1},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_SET, 32'sd0, POS_MIN, 1'b1, POS_MIN, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, -32'sd1, 48'sd0, 1'b1, POS_MIN, -32'sd1},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, CNT_MIN, 48'sd0, 1'b1, POS_MIN,
      32'sh8000_0001},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, CNT_MAX, 48'sd0, 1'b1, POS_MIN, -32'sd1},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, POS_MAX, 1'b1, POS_MAX, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, POS_MIN, 1'b1, POS_MIN, 32'sd1},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, -48'sd1, 1'b1, -48'sd1, CNT_MIN},
    '{STEP_WRITE, REG_CNT_PER_VAL, 32'hFFFF_FFFF, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0,
      32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, POS_MAX, 1'b1, POS_MAX, CNT_MAX},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, POS_MIN, 1'b1, POS_MIN, 32'sd1},
    '{STEP_WRITE, REG_CNT_PER_VAL, 32'd0, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_ENCODE, 32'sd0, 48'sh1234_5678_9ABC, 1'b1,
      48'sh1234_5678_9ABC, CNT_MIN},
    '{STEP_WRITE, REG_RESOLUTION, 32'd4, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_WRITE, REG_VAL_PER_CNT, 32'hFFFF_FFFF, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0,
      32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_SET, 32'sd0, 48'sd0, 1'b1, 48'sd0, 32'sd0},
    // half range of a 4-bit counter, then just past it both ways
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd8, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd17, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd8, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    // zero resolution behaves as a 1-bit counter
    '{STEP_WRITE, REG_RESOLUTION, 32'd0, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd10, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd9, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    // oversized resolution behaves as 32 bits; big step hits the product clamp
    '{STEP_WRITE, REG_RESOLUTION, 32'd63, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, CNT_MIN, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_WRITE, REG_RESOLUTION, 32'd1, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_WRITE, REG_VAL_PER_CNT, 32'd0, CMD_NONE, 32'sd0, 48'sd0, 1'b0, 48'sd0, 32'sd0},
    '{STEP_ITEM, REG_RESOLUTION, 32'd0, CMD_DECODE, 32'sd12345, 48'sd0, 1'b0, 48'sd0, 32'sd0}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  cmd_t in_command;
  count_t in_count_in;
  value_t in_value_in;
  logic out_valid;
  logic out_ready;
  value_t out_value_out;
  count_t out_count_delta;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;

  // tracked copy of the block's registers and state
  logic [5:0] trk_res;
  logic [31:0] trk_vpc;
  logic [31:0] trk_cpv;
  count_t trk_last;
  value_t trk_pos;

  pos_report_t expected_reports[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_checked;
  int quiet_cycles;
  int n_decode, n_encode, n_set, n_unused;

  encoder_count_unwrap_accumulator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_count_in     (in_count_in),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value_out   (out_value_out),
    .out_count_delta (out_count_delta),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int effective_bits();
    if (trk_res == 6'd0) return 1;
    if (trk_res > 6'd32) return 32;
    return int'(trk_res);
  endfunction

  // Apply one command to the tracked state and return the position report it produces.
  function automatic pos_report_t track_command(cmd_t c, count_t cin, value_t vin);
    pos_report_t rep;
    count_t raw;
    count_t dlt;
    count_t n;
    int eff;
    logic signed [63:0] d, lim, wide_d, scale, prod, sum, wide_pos;
    logic neg;
    logic [47:0] mag;
    logic [79:0] prod80;
    logic [47:0] q;
    dlt = '0;
    case (c)
      CMD_DECODE: begin
        raw = cin - trk_last;
        d = raw;
        eff = effective_bits();
        if (eff < 32) begin
          lim = 64'sd1 <<< (eff - 1);
          if (d < -lim) d = d + 2 * lim;
          else if (d > lim) d = d - 2 * lim;
        end
        dlt = d[31:0];
        wide_d = dlt;
        scale = {32'd0, trk_vpc};
        prod = wide_d * scale;
        if (prod > DECODE_CLAMP) prod = DECODE_CLAMP;
        else if (prod < -DECODE_CLAMP) prod = -DECODE_CLAMP;
        wide_pos = trk_pos;
        sum = wide_pos + prod;
        if (sum > POS_HI) trk_pos = POS_MAX;
        else if (sum < POS_LO) trk_pos = POS_MIN;
        else trk_pos = sum[47:0];
        trk_last = cin;
      end
      CMD_ENCODE: begin
        neg = (vin < 0);
        mag = neg ? -vin : vin;
        prod80 = {32'd0, mag} * {48'd0, trk_cpv};
        q = prod80[79:32];
        if (neg) n = (q > 48'h8000_0000) ? CNT_MIN : -q[31:0];
        else n = (q > 48'h7FFF_FFFF) ? CNT_MAX : q[31:0];
        dlt = n - trk_last;
        trk_last = n;
        trk_pos = vin;
      end
      CMD_SET: begin
        trk_last = cin;
        trk_pos = vin;
      end
      default: ;
    endcase
    rep.pos = trk_pos;
    rep.delta = dlt;
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("mismatch at %0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Present one transaction and hold it until accepted.
  task automatic send_command(input cmd_t c, input count_t cnt, input value_t val,
                              input logic has_want, input pos_report_t want);
    pos_report_t rep;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_count_in <= cnt;
    in_value_in <= val;
    do @(posedge clk); while (!in_ready);
    rep = track_command(c, cnt, val);
    expected_reports.push_back(has_want ? want : rep);
    case (c)
      CMD_DECODE: n_decode++;
      CMD_ENCODE: n_encode++;
      CMD_SET:    n_set++;
      default:    n_unused++;
    endcase
  endtask

  // Hold the input side until every pending result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RESOLUTION:  trk_res = data[5:0];
      REG_VAL_PER_CNT: trk_vpc = data;
      REG_CNT_PER_VAL: trk_cpv = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : result_check
    pos_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing pending", {16'd0, out_value_out}, '0);
      end else begin
        want = expected_reports.pop_front();
        if (out_value_out !== want.pos)
          report_mismatch("value_out", {16'd0, out_value_out}, {16'd0, want.pos});
        if (out_count_delta !== want.delta)
          report_mismatch("count_delta", {32'd0, out_count_delta}, {32'd0, want.delta});
      end
      results_checked++;
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 STALL_LIMIT, expected_reports.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_step_t row;
    pos_report_t fixed;
    cmd_t c;
    count_t cnt, step;
    value_t val;
    logic [31:0] mask;
    logic [5:0] res_sel;
    logic [31:0] vpc_sel, cpv_sel;
    int r, eff;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_NONE;
    in_count_in = '0;
    in_value_in = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RESOLUTION;
    cfg_wdata = '0;
    trk_res = RES_RESET;
    trk_vpc = SCALE_ONE;
    trk_cpv = SCALE_ONE;
    trk_last = '0;
    trk_pos = '0;
    send_idle_pct = 27;
    recv_idle_pct = 88;
    mismatches = 0;
    results_checked = 0;
    quiet_cycles = 0;
    n_decode = 0;
    n_encode = 0;
    n_set = 0;
    n_unused = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == STEP_WRITE) begin
        drain_results();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        fixed.pos = row.want_pos;
        fixed.delta = row.want_delta;
        send_command(row.cmd, row.cnt, row.val, row.has_want, fixed);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 88;
      end else if (p < 4) begin
        send_idle_pct = 88;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin
          res_sel = RES_RESET;
          vpc_sel = SCALE_ONE;
          cpv_sel = SCALE_ONE;
        end
        1: begin
          res_sel = 6'd1;
          vpc_sel = 32'hFFFF_FFFF;
          cpv_sel = 32'hFFFF_FFFF;
        end
        2: begin
          res_sel = 6'($urandom_range(2, 31));
          vpc_sel = $urandom >> $urandom_range(0, 31);
          cpv_sel = $urandom >> $urandom_range(0, 31);
        end
        3: begin
          res_sel = ($urandom_range(0, 3) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
          vpc_sel = 32'd0;
          cpv_sel = $urandom;
        end
        4: begin
          res_sel = 6'd16;
          vpc_sel = $urandom;
          cpv_sel = SCALE_ONE;
        end
        default: begin
          res_sel = 6'($urandom_range(0, 63));
          vpc_sel = $urandom;
          cpv_sel = $urandom;
        end
      endcase
      write_reg(REG_RESOLUTION, {26'd0, res_sel});
      write_reg(REG_VAL_PER_CNT, vpc_sel);
      write_reg(REG_CNT_PER_VAL, cpv_sel);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase until the pipe has emptied
        if (k == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 99);
        val = 48'({$urandom, $urandom});
        val = val >>> $urandom_range(0, 40);
        cnt = $urandom;
        c = CMD_DECODE;
        if (r < 55) begin
          // counter reading a plausible distance from the last one, wrapped to its width
          eff = effective_bits();
          step = $urandom;
          step = step >>> (32 - eff);
          step = step >>> $urandom_range(0, eff - 1);
          mask = (eff == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << eff) - 1);
          cnt = (trk_last + step) & mask;
        end else if (r < 63) begin
          c = CMD_DECODE;
        end else if (r < 76) begin
          c = CMD_ENCODE;
        end else if (r < 88) begin
          c = CMD_SET;
        end else if (r < 93) begin
          c = CMD_NONE;
        end else begin
          c = cmd_t'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0: cnt = CNT_MIN;
            1: cnt = CNT_MAX;
            2: cnt = '0;
            default: cnt = '1;
          endcase
          case ($urandom_range(0, 3))
            0: val = POS_MIN;
            1: val = POS_MAX;
            2: val = '0;
            default: val = '1;
          endcase
        end
        send_command(c, cnt, val, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d commands (%0d decode, %0d encode, %0d set, %0d unused), %0d checked",
             n_decode + n_encode + n_set + n_unused, n_decode, n_encode, n_set, n_unused,
             results_checked);
    $display("summary: %0d register settings incl. resolution 0/1/32/63, %0d mismatches",
             PHASES + 4, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
